// File: design/schc_pkg.sv
// Shared types and constants of the skin color histogram classifier.
// Depends on nothing; imported by the top level.
package schc_pkg;

  localparam int BIN_BITS_DEF   = 5;
  localparam int COUNT_BITS_DEF = 24;

  localparam int CHAN_W    = 8;
  localparam int TOTAL_W   = 32;
  localparam int THR_W     = 20;
  localparam int FRAC_BITS = 16;

  localparam int IN_DATA_W  = 6 * CHAN_W;
  localparam int OUT_DATA_W = 3 * CHAN_W;

  localparam logic [CHAN_W-1:0] MASK_LEVEL_RST = CHAN_W'(250);
  localparam logic [THR_W-1:0]  RATIO_THR_RST  = THR_W'(26214);
  localparam logic [CHAN_W-1:0] WHITE_LEVEL    = CHAN_W'(255);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = THR_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LEVEL      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_THRESHOLD = CFG_INDEX_W'(1);

  localparam logic ACT_TRAIN    = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_CMP
  } state_t;

endpackage

// File: design/schc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module schc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/skin_color_histogram_classifier.sv
// Histogram-based skin color classifier: top level with FSM, totals and compare.
// Depends on schc_pkg and schc_ram.
//
// Each request on the slave stream is a training pixel (tuser = 0) or a
// classify pixel (tuser = 1). Color bins are the top BIN_BITS of each
// channel, so each histogram holds 2^(3*BIN_BITS) saturating counters in a
// RAM with registered read. A training pixel reads its bin, then writes
// back the incremented count and bumps the matching total. A classify
// pixel reads both bins, multiplies, finishes the wide product with two
// partial products, then compares and loads the output register. One
// pixel is in flight at a time. A result that the master side has not yet
// taken does not block training pixels, only the next classify result.
// After reset the block sweeps all 2^(3*BIN_BITS) bins of both RAMs (32768
// at the default) to zero, one bin per cycle, and accepts no pixel until
// done; configuration writes are taken at any time but are meant for idle
// periods. A pixel is whitened when its non-skin count is zero or when
// skin*nonskin_total*2^16 <= ratio_threshold*nonskin*skin_total, all exact.
module skin_color_histogram_classifier
  import schc_pkg::*;
#(
  parameter int BIN_BITS   = BIN_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [7:0] pix_red, [15:8] pix_green, [23:16] pix_blue,
  // [31:24] mask_red, [39:32] mask_green, [47:40] mask_blue
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // [0] action (0 = training, 1 = classify)
  input  logic                   s_tuser,
  // master stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // [0] is_skin
  output logic                   m_tuser,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = 3 * BIN_BITS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PS_W   = COUNT_BITS + TOTAL_W;   // skin count * nonskin total
  localparam int PN_W   = COUNT_BITS + THR_W;     // nonskin count * threshold
  localparam int PL_W   = PN_W / 2;
  localparam int PH_W   = PN_W - PL_W;
  localparam int RL_W   = PL_W + TOTAL_W;
  localparam int RH_W   = PH_W + TOTAL_W;
  localparam int CMP_W  = PN_W + TOTAL_W;

  state_t state, state_next;

  logic [CHAN_W-1:0]     mask_level;
  logic [THR_W-1:0]      ratio_threshold;
  logic [TOTAL_W-1:0]    skin_total;
  logic [TOTAL_W-1:0]    nonskin_total;
  logic [ADDR_W-1:0]     clr_addr;

  // held request
  logic                  act;
  logic                  is_nonskin;
  logic [ADDR_W-1:0]     bin;
  logic [CHAN_W-1:0]     pix_r, pix_g, pix_b;

  // product chain
  logic [PS_W-1:0]       ps;
  logic [PN_W-1:0]       pn;
  logic [RL_W-1:0]       rl;
  logic [RH_W-1:0]       rh;
  logic                  n_zero;

  logic                  accept;
  logic                  slot_free;
  logic                  out_load;
  logic                  whiten;
  logic [CMP_W-1:0]      lhs, rhs;

  logic [CHAN_W-1:0]     in_r, in_g, in_b, in_mr, in_mg, in_mb;
  logic [ADDR_W-1:0]     in_bin;
  logic                  in_nonskin;

  logic                  we_skin, we_nonskin, ram_re;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata_skin, wdata_nonskin;
  logic [COUNT_BITS-1:0] rd_skin, rd_nonskin;
  logic [COUNT_BITS-1:0] inc_skin, inc_nonskin;

  // Unpack the request and form the bin index from the top bits of each channel.
  assign in_r  = s_tdata[0*CHAN_W +: CHAN_W];
  assign in_g  = s_tdata[1*CHAN_W +: CHAN_W];
  assign in_b  = s_tdata[2*CHAN_W +: CHAN_W];
  assign in_mr = s_tdata[3*CHAN_W +: CHAN_W];
  assign in_mg = s_tdata[4*CHAN_W +: CHAN_W];
  assign in_mb = s_tdata[5*CHAN_W +: CHAN_W];

  assign in_bin = {in_r[CHAN_W-1 -: BIN_BITS], in_g[CHAN_W-1 -: BIN_BITS],
                   in_b[CHAN_W-1 -: BIN_BITS]};
  // Non-skin only when all three mask channels are above the level.
  assign in_nonskin = (in_mr > mask_level) && (in_mg > mask_level) &&
                      (in_mb > mask_level);

  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Histogram RAMs.
  schc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_skin_ram (
    .clk   (clk),
    .we    (we_skin),
    .waddr (waddr),
    .wdata (wdata_skin),
    .re    (ram_re),
    .raddr (in_bin),
    .rdata (rd_skin)
  );

  schc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_nonskin_ram (
    .clk   (clk),
    .we    (we_nonskin),
    .waddr (waddr),
    .wdata (wdata_nonskin),
    .re    (ram_re),
    .raddr (in_bin),
    .rdata (rd_nonskin)
  );

  // Saturating increments of the bins just read.
  assign inc_skin    = (rd_skin == '1) ? rd_skin : rd_skin + 1'b1;
  assign inc_nonskin = (rd_nonskin == '1) ? rd_nonskin : rd_nonskin + 1'b1;

  // Final compare: left side shifted by the threshold's fraction bits,
  // right side rebuilt from its two partial products.
  assign lhs    = CMP_W'(ps) << FRAC_BITS;
  assign rhs    = (CMP_W'(rh) << PL_W) + CMP_W'(rl);
  assign whiten = n_zero || (lhs <= rhs);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = (act == ACT_CLASSIFY) ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_tready      = 1'b0;
    ram_re        = 1'b0;
    we_skin       = 1'b0;
    we_nonskin    = 1'b0;
    waddr         = bin;
    wdata_skin    = inc_skin;
    wdata_nonskin = inc_nonskin;
    out_load      = 1'b0;
    case (state)
      ST_CLEAR: begin
        // Sweep both histograms to zero.
        we_skin       = 1'b1;
        we_nonskin    = 1'b1;
        waddr         = clr_addr;
        wdata_skin    = '0;
        wdata_nonskin = '0;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
      end
      ST_LOOK: begin
        // Write back the incremented bin of a training pixel.
        we_skin    = (act == ACT_TRAIN) && !is_nonskin;
        we_nonskin = (act == ACT_TRAIN) && is_nonskin;
      end
      ST_MUL: begin
        s_tready = 1'b0;
      end
      ST_CMP: begin
        out_load = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      mask_level      <= MASK_LEVEL_RST;
      ratio_threshold <= RATIO_THR_RST;
      skin_total      <= '0;
      nonskin_total   <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MASK_LEVEL:      mask_level      <= cfg_data[CHAN_W-1:0];
          CFG_RATIO_THRESHOLD: ratio_threshold <= cfg_data[THR_W-1:0];
          default: begin
            // ignore writes to unknown registers
          end
        endcase
      end

      // Advance the matching total alongside the bin write.
      if (we_skin && state == ST_LOOK && skin_total != '1) begin
        skin_total <= skin_total + 1'b1;
      end
      if (we_nonskin && state == ST_LOOK && nonskin_total != '1) begin
        nonskin_total <= nonskin_total + 1'b1;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act        <= s_tuser;
      is_nonskin <= in_nonskin;
      bin        <= in_bin;
      pix_r      <= in_r;
      pix_g      <= in_g;
      pix_b      <= in_b;
    end
    if (state == ST_LOOK) begin
      ps     <= PS_W'(rd_skin) * PS_W'(nonskin_total);
      pn     <= PN_W'(rd_nonskin) * PN_W'(ratio_threshold);
      n_zero <= (rd_nonskin == '0);
    end
    if (state == ST_MUL) begin
      rl <= RL_W'(pn[PL_W-1:0]) * RL_W'(skin_total);
      rh <= RH_W'(pn[PN_W-1:PL_W]) * RH_W'(skin_total);
    end
    if (out_load) begin
      if (whiten) begin
        m_tdata <= {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {pix_b, pix_g, pix_r};
        m_tuser <= 1'b1;
      end
    end
  end

  // A request accepted is always looked up in the following cycle.
  a_accept_look : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOK)
    else $error("accepted request did not enter lookup");

  // Totals never move backward outside reset.
  a_skin_total_mono : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> skin_total >= $past(skin_total))
    else $error("skin total decreased");

  a_nonskin_total_mono : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> nonskin_total >= $past(nonskin_total))
    else $error("nonskin total decreased");

  // A training pixel updates exactly one histogram.
  a_one_hist : assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |-> !(we_skin && we_nonskin))
    else $error("both histograms written for one pixel");

  // A whitened result carries white pixels.
  a_white : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL})
    else $error("non-skin result is not white");

endmodule
